FILE: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants for the preemptive priority scheduler unit.
// ----------------------------------------------------------------------------
package pps_pkg;

  // fixed widths of the item fields
  localparam int TF_W   = 16;
  localparam int SLOT_FW = 3;
  localparam int PRIO_W = 4;

  // request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // one task slot as held in the slot memory
  typedef struct packed {
    logic [TF_W-1:0]   arrival;
    logic [TF_W-1:0]   burst;
    logic [TF_W-1:0]   left;
    logic [PRIO_W-1:0] prio;
  } slot_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic scan;
    logic pick;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } dp_status_t;

endpackage

FILE: rtl/core/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for load and tick items: load, slot scan, drain, pick, execute.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                req_type,
  input  pps_pkg::dp_status_t status,
  output pps_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  pps_pkg::state_t state;
  pps_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pps_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (req_type == pps_pkg::REQ_LOAD) ? pps_pkg::ST_LOAD : pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_LOAD:  state_next = pps_pkg::ST_IDLE;
      pps_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_next = pps_pkg::ST_DRAIN;
        end
      end
      pps_pkg::ST_DRAIN: state_next = pps_pkg::ST_PICK;
      pps_pkg::ST_PICK:  state_next = pps_pkg::ST_EXEC;
      pps_pkg::ST_EXEC:  state_next = pps_pkg::ST_IDLE;
      default:           state_next = pps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      pps_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      pps_pkg::ST_LOAD:  cmd.load = 1'b1;
      pps_pkg::ST_SCAN:  cmd.scan = 1'b1;
      pps_pkg::ST_DRAIN: cmd      = '0;
      pps_pkg::ST_PICK:  cmd.pick = 1'b1;
      pps_pkg::ST_EXEC:  cmd.exec = 1'b1;
      default:           cmd      = '0;
    endcase
  end

endmodule

FILE: rtl/core/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath
// Slot memory, slot flags, running-task registers, scan comparator and
// result registers of the scheduler.
// ----------------------------------------------------------------------------
module pps_datapath #(
  parameter int NUM_SLOTS = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pps_pkg::ctrl_cmd_t                  cmd,
  output pps_pkg::dp_status_t                 status,
  input  logic [pps_pkg::SLOT_FW-1:0]         slot,
  input  logic [pps_pkg::TF_W-1:0]            arrival,
  input  logic [pps_pkg::TF_W-1:0]            burst,
  input  logic [pps_pkg::PRIO_W-1:0]          prio_level,
  output logic                                done,
  output logic                                ran,
  output logic [pps_pkg::SLOT_FW-1:0]         run_slot,
  output logic                                preempted,
  output logic                                first_run,
  output logic [pps_pkg::TF_W-1:0]            response,
  output logic                                finished,
  output logic [pps_pkg::TF_W-1:0]            turnaround,
  output logic [pps_pkg::TF_W-1:0]            waiting,
  output logic                                all_done,
  output logic [pps_pkg::TF_W-1:0]            time_now
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int EXT_W  = ((TIME_BITS > pps_pkg::TF_W) ? TIME_BITS : pps_pkg::TF_W) + 1;

  // slot memory and per-slot flags
  pps_pkg::slot_entry_t mem [NUM_SLOTS];
  pps_pkg::slot_entry_t rd_data;
  logic [SLOT_W-1:0]    rd_addr;
  logic [SLOT_W-1:0]    rd_slot;
  logic                 rd_scan;

  logic [NUM_SLOTS-1:0] slot_loaded;
  logic [NUM_SLOTS-1:0] slot_done;
  logic [NUM_SLOTS-1:0] slot_started;

  // latched request
  logic [pps_pkg::SLOT_FW-1:0] req_slot;
  logic [pps_pkg::TF_W-1:0]    req_arrival;
  logic [pps_pkg::TF_W-1:0]    req_burst;
  logic [pps_pkg::PRIO_W-1:0]  req_prio;

  // running task
  logic                        active_valid;
  logic [SLOT_W-1:0]           active_slot;
  logic [pps_pkg::PRIO_W-1:0]  active_prio;
  logic [pps_pkg::TF_W-1:0]    active_arr;

  // scan state
  logic [SLOT_W-1:0]           scan_cnt;
  logic                        best_found;
  logic [SLOT_W-1:0]           best_slot;
  logic [pps_pkg::PRIO_W-1:0]  best_prio;
  logic [pps_pkg::TF_W-1:0]    best_arr;

  logic [TIME_BITS-1:0]        clock_time;
  logic [TIME_BITS-1:0]        time_inc;
  logic                        preempt_q;
  logic [pps_pkg::TF_W-1:0]    resp_q;
  logic [EXT_W-1:0]            ta_q;

  // load
  logic                 ld_ok;
  logic [SLOT_W-1:0]    ld_idx;
  pps_pkg::slot_entry_t ld_entry;

  // scan compare
  logic cand_ok;
  logic cand_better;

  // pick
  logic                       pick_take;
  logic [SLOT_W-1:0]          new_slot;
  logic [pps_pkg::TF_W-1:0]   new_arr;
  logic [EXT_W-1:0]           resp_diff;
  logic [EXT_W-1:0]           ta_diff;

  // execute
  logic [pps_pkg::TF_W-1:0]   left_new;
  logic                       ex_fin;
  logic                       ex_first;
  logic [EXT_W-1:0]           wait_diff;
  pps_pkg::slot_entry_t       ex_entry;

  // result next values
  logic                        ran_next;
  logic [pps_pkg::SLOT_FW-1:0] run_slot_next;
  logic                        preempted_next;
  logic                        first_run_next;
  logic [pps_pkg::TF_W-1:0]    response_next;
  logic                        finished_next;
  logic [pps_pkg::TF_W-1:0]    turnaround_next;
  logic [pps_pkg::TF_W-1:0]    waiting_next;

  assign status.scan_last = (scan_cnt == SLOT_W'(NUM_SLOTS - 1));

  // ---------------------------------------------------------------- load
  assign ld_ok  = int'(req_slot) < NUM_SLOTS;
  assign ld_idx = SLOT_W'(req_slot);
  always_comb begin
    ld_entry.arrival = req_arrival;
    ld_entry.burst   = req_burst;
    ld_entry.left    = req_burst;
    ld_entry.prio    = req_prio;
  end

  // ---------------------------------------------------------------- scan
  assign cand_ok = slot_loaded[rd_slot] && !slot_done[rd_slot] && (rd_data.left != '0) &&
                   (EXT_W'(rd_data.arrival) <= EXT_W'(clock_time));
  assign cand_better = !best_found || (rd_data.prio < best_prio) ||
                       ((rd_data.prio == best_prio) && (rd_data.arrival < best_arr));

  // ---------------------------------------------------------------- pick
  assign pick_take = best_found &&
                     (!active_valid ||
                      ((best_slot != active_slot) &&
                       ((best_prio < active_prio) ||
                        ((best_prio == active_prio) && (best_arr < active_arr)))));
  assign new_slot  = pick_take ? best_slot : active_slot;
  assign new_arr   = pick_take ? best_arr : active_arr;
  assign resp_diff = EXT_W'(clock_time) - EXT_W'(new_arr);
  assign ta_diff   = EXT_W'(time_inc) - EXT_W'(new_arr);

  // scan reads walk the slots, pick reads the task about to run
  assign rd_addr = cmd.pick ? new_slot : scan_cnt;

  // ---------------------------------------------------------------- execute
  assign left_new  = rd_data.left - pps_pkg::TF_W'(1);
  assign ex_fin    = (left_new == '0);
  assign ex_first  = !slot_started[active_slot];
  assign wait_diff = ta_q - EXT_W'(rd_data.burst);
  always_comb begin
    ex_entry      = rd_data;
    ex_entry.left = left_new;
  end

  always_comb begin
    ran_next        = 1'b0;
    run_slot_next   = '0;
    preempted_next  = 1'b0;
    first_run_next  = 1'b0;
    response_next   = '0;
    finished_next   = 1'b0;
    turnaround_next = '0;
    waiting_next    = '0;
    if (cmd.exec && active_valid) begin
      ran_next       = 1'b1;
      run_slot_next  = pps_pkg::SLOT_FW'(active_slot);
      preempted_next = preempt_q;
      first_run_next = ex_first;
      if (ex_first) begin
        response_next = resp_q;
      end
      if (ex_fin) begin
        finished_next   = 1'b1;
        turnaround_next = (ta_q[EXT_W-1:pps_pkg::TF_W] != '0) ? '1 : ta_q[pps_pkg::TF_W-1:0];
        if (ta_q > EXT_W'(rd_data.burst)) begin
          waiting_next = (wait_diff[EXT_W-1:pps_pkg::TF_W] != '0) ? '1 :
                         wait_diff[pps_pkg::TF_W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------- storage
  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok) begin
      mem[ld_idx] <= ld_entry;
    end else if (cmd.exec && active_valid) begin
      mem[active_slot] <= ex_entry;
    end
    rd_data <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_slot  <= scan_cnt;
    time_inc <= (clock_time == '1) ? clock_time : clock_time + TIME_BITS'(1);
    if (cmd.accept) begin
      req_slot    <= slot;
      req_arrival <= arrival;
      req_burst   <= burst;
      req_prio    <= prio_level;
    end
    if (rd_scan && cand_ok && cand_better) begin
      best_slot <= rd_slot;
      best_prio <= rd_data.prio;
      best_arr  <= rd_data.arrival;
    end
    if (cmd.pick) begin
      resp_q <= (resp_diff[EXT_W-1:pps_pkg::TF_W] != '0) ? '1 : resp_diff[pps_pkg::TF_W-1:0];
      ta_q   <= ta_diff;
      if (pick_take) begin
        active_prio <= best_prio;
        active_arr  <= best_arr;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_loaded  <= '0;
      slot_done    <= '0;
      slot_started <= '0;
      active_valid <= 1'b0;
      active_slot  <= '0;
      clock_time   <= '0;
      scan_cnt     <= '0;
      best_found   <= 1'b0;
      preempt_q    <= 1'b0;
      rd_scan      <= 1'b0;
      done         <= 1'b0;
      ran          <= 1'b0;
      run_slot     <= '0;
      preempted    <= 1'b0;
      first_run    <= 1'b0;
      response     <= '0;
      finished     <= 1'b0;
      turnaround   <= '0;
      waiting      <= '0;
    end else begin
      rd_scan <= cmd.scan;
      done    <= cmd.load || cmd.exec;
      if (cmd.load || cmd.exec) begin
        ran        <= ran_next;
        run_slot   <= run_slot_next;
        preempted  <= preempted_next;
        first_run  <= first_run_next;
        response   <= response_next;
        finished   <= finished_next;
        turnaround <= turnaround_next;
        waiting    <= waiting_next;
      end
      if (cmd.accept) begin
        scan_cnt   <= '0;
        best_found <= 1'b0;
        preempt_q  <= 1'b0;
      end
      if (cmd.scan) begin
        scan_cnt <= scan_cnt + SLOT_W'(1);
      end
      if (rd_scan && cand_ok) begin
        best_found <= 1'b1;
      end
      if (cmd.load && ld_ok) begin
        slot_loaded[ld_idx]  <= 1'b1;
        slot_started[ld_idx] <= 1'b0;
        slot_done[ld_idx]    <= (req_burst == '0);
        if (active_valid && (active_slot == ld_idx)) begin
          active_valid <= 1'b0;
        end
      end
      if (cmd.pick && pick_take) begin
        active_valid <= 1'b1;
        active_slot  <= best_slot;
        preempt_q    <= active_valid;
      end
      if (cmd.exec) begin
        clock_time <= time_inc;
        if (active_valid) begin
          slot_started[active_slot] <= 1'b1;
          if (ex_fin) begin
            slot_done[active_slot] <= 1'b1;
            active_valid           <= 1'b0;
          end
        end
      end
    end
  end

  assign all_done = (|slot_loaded) && (&(slot_done | ~slot_loaded));
  assign time_now = pps_pkg::TF_W'(clock_time);

  // the running task is always a loaded, unfinished slot
  a_active_consistent: assert property (@(posedge clk) disable iff (rst)
    active_valid |-> (slot_loaded[active_slot] && !slot_done[active_slot]))
    else $error("running task is not a loaded unfinished slot");

  // scheduler time never moves backwards
  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (clock_time >= $past(clock_time)))
    else $error("scheduler time decreased");

endmodule

FILE: rtl/core/preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Preemptive priority scheduler over a table of task slots: load and tick items.
// ----------------------------------------------------------------------------
// sequence: a load result strobes after the load state, a tick result after the slot
// scan and the drain, pick and execute states; the scan makes one memory read a cycle
// items: a new item is accepted only while idle, so one item finishes before the next starts
// reset: synchronous rst clears all slot flags, the running task and the time
// results are strobed on done for one cycle and cannot be held off
module preemptive_priority_scheduler_unit #(
  parameter int NUM_SLOTS = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type,
  input  logic [pps_pkg::SLOT_FW-1:0] slot,
  input  logic [pps_pkg::TF_W-1:0]    arrival,
  input  logic [pps_pkg::TF_W-1:0]    burst,
  input  logic [pps_pkg::PRIO_W-1:0]  prio_level,
  output logic                        done,
  output logic                        ran,
  output logic [pps_pkg::SLOT_FW-1:0] run_slot,
  output logic                        preempted,
  output logic                        first_run,
  output logic [pps_pkg::TF_W-1:0]    response,
  output logic                        finished,
  output logic [pps_pkg::TF_W-1:0]    turnaround,
  output logic [pps_pkg::TF_W-1:0]    waiting,
  output logic                        all_done,
  output logic [pps_pkg::TF_W-1:0]    time_now
);

  pps_pkg::ctrl_cmd_t  cmd;
  pps_pkg::dp_status_t status;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  pps_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .slot       (slot),
    .arrival    (arrival),
    .burst      (burst),
    .prio_level (prio_level),
    .done       (done),
    .ran        (ran),
    .run_slot   (run_slot),
    .preempted  (preempted),
    .first_run  (first_run),
    .response   (response),
    .finished   (finished),
    .turnaround (turnaround),
    .waiting    (waiting),
    .all_done   (all_done),
    .time_now   (time_now)
  );

  // one result per item, so strobes never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // task flags only come with a task that ran
  a_flags_need_run: assert property (@(posedge clk) disable iff (rst)
    (done && (finished || first_run || preempted)) |-> ran)
    else $error("task flag set on a result with no task run");

  // the unit is free again when its result is shown
  a_idle_at_result: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while a result is strobed");

endmodule

FILE: bench/tb_preemptive_priority_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler_unit
// Self-checking bench for the preemptive priority scheduler unit. Load and tick
// items go in over the start/busy handshake. An in-bench scheduler model
// predicts every strobed result, which is then checked field by field. The run
// has directed cases followed by a long random phase.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS    = 8;
  localparam int TIME_TOP = 65535;

  typedef struct packed {
    logic                          ran;
    logic [pps_pkg::SLOT_FW-1:0]   run_slot;
    logic                          preempted;
    logic                          first_run;
    logic [pps_pkg::TF_W-1:0]      response;
    logic                          finished;
    logic [pps_pkg::TF_W-1:0]      turnaround;
    logic [pps_pkg::TF_W-1:0]      waiting;
    logic                          all_done;
    logic [pps_pkg::TF_W-1:0]      time_now;
  } sched_out_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          req_type = pps_pkg::REQ_LOAD;
  logic [pps_pkg::SLOT_FW-1:0]   slot = '0;
  logic [pps_pkg::TF_W-1:0]      arrival = '0;
  logic [pps_pkg::TF_W-1:0]      burst = '0;
  logic [pps_pkg::PRIO_W-1:0]    prio_level = '0;
  logic                          done;
  logic                          ran;
  logic [pps_pkg::SLOT_FW-1:0]   run_slot;
  logic                          preempted;
  logic                          first_run;
  logic [pps_pkg::TF_W-1:0]      response;
  logic                          finished;
  logic [pps_pkg::TF_W-1:0]      turnaround;
  logic [pps_pkg::TF_W-1:0]      waiting;
  logic                          all_done;
  logic [pps_pkg::TF_W-1:0]      time_now;

  preemptive_priority_scheduler_unit u_dut (.*);

  always #5 clk = ~clk;

  // scheduler model state
  pps_pkg::slot_entry_t slot_tbl [SLOTS];
  logic [SLOTS-1:0]     is_loaded = '0;
  logic [SLOTS-1:0]     is_done = '0;
  logic [SLOTS-1:0]     is_started = '0;
  bit                   running = 1'b0;
  int                   run_idx = 0;
  int                   sched_time = 0;

  sched_out_t           pending_outs [$];
  sched_out_t           want;
  int                   fail_count = 0;

  function automatic bit outranks(int x, int y);
    if (slot_tbl[x].prio != slot_tbl[y].prio) return slot_tbl[x].prio < slot_tbl[y].prio;
    return slot_tbl[x].arrival < slot_tbl[y].arrival;
  endfunction

  function automatic void advance_time();
    if (sched_time < TIME_TOP) sched_time++;
  endfunction

  function automatic sched_out_t schedule_step(input logic rq,
                                               input logic [pps_pkg::SLOT_FW-1:0] s,
                                               input logic [pps_pkg::TF_W-1:0] a,
                                               input logic [pps_pkg::TF_W-1:0] b,
                                               input logic [pps_pkg::PRIO_W-1:0] p);
    sched_out_t r;
    bit         found;
    int         best;
    int         ta;
    int         bl;
    r = '0;
    found = 1'b0;
    best = 0;
    if (rq == pps_pkg::REQ_LOAD) begin
      slot_tbl[s].arrival = a;
      slot_tbl[s].burst = b;
      slot_tbl[s].left = b;
      slot_tbl[s].prio = p;
      is_loaded[s] = 1'b1;
      is_started[s] = 1'b0;
      is_done[s] = (b == '0);
      if (running && run_idx == int'(s)) running = 1'b0;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (is_loaded[i] && !is_done[i] && slot_tbl[i].left != '0 &&
            int'(slot_tbl[i].arrival) <= sched_time) begin
          if (!found || outranks(i, best)) begin
            best = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        if (!running) begin
          running = 1'b1;
          run_idx = best;
        end else if (best != run_idx && outranks(best, run_idx)) begin
          run_idx = best;
          r.preempted = 1'b1;
        end
      end
      if (!running) begin
        advance_time();
      end else begin
        r.ran = 1'b1;
        r.run_slot = run_idx[pps_pkg::SLOT_FW-1:0];
        if (!is_started[run_idx]) begin
          is_started[run_idx] = 1'b1;
          r.first_run = 1'b1;
          r.response = pps_pkg::TF_W'(sched_time - int'(slot_tbl[run_idx].arrival));
        end
        slot_tbl[run_idx].left = slot_tbl[run_idx].left - pps_pkg::TF_W'(1);
        advance_time();
        if (slot_tbl[run_idx].left == '0) begin
          ta = sched_time - int'(slot_tbl[run_idx].arrival);
          bl = int'(slot_tbl[run_idx].burst);
          is_done[run_idx] = 1'b1;
          running = 1'b0;
          r.finished = 1'b1;
          r.turnaround = pps_pkg::TF_W'(ta);
          // saturated time can leave turnaround below burst
          r.waiting = (ta > bl) ? pps_pkg::TF_W'(ta - bl) : '0;
        end
      end
    end
    r.all_done = (is_loaded != '0) && ((is_loaded & ~is_done) == '0);
    r.time_now = pps_pkg::TF_W'(sched_time);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_outs.size() == 0) begin
        $error("result strobed with no item outstanding");
        fail_count++;
      end else begin
        want = pending_outs.pop_front();
        check_field("ran", want.ran, ran);
        check_field("run_slot", want.run_slot, run_slot);
        check_field("preempted", want.preempted, preempted);
        check_field("first_run", want.first_run, first_run);
        check_field("response", want.response, response);
        check_field("finished", want.finished, finished);
        check_field("turnaround", want.turnaround, turnaround);
        check_field("waiting", want.waiting, waiting);
        check_field("all_done", want.all_done, all_done);
        check_field("time_now", want.time_now, time_now);
      end
    end
  end

  // start stays high into the next item, so it is only lowered by the idle tasks
  task automatic send_item(input logic rq, input logic [pps_pkg::SLOT_FW-1:0] s,
                           input logic [pps_pkg::TF_W-1:0] a,
                           input logic [pps_pkg::TF_W-1:0] b,
                           input logic [pps_pkg::PRIO_W-1:0] p);
    req_type <= rq;
    slot <= s;
    arrival <= a;
    burst <= b;
    prio_level <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_outs.push_back(schedule_step(rq, s, a, b, p));
  endtask

  task automatic load_slot(input int s, input int a, input int b, input int p);
    send_item(pps_pkg::REQ_LOAD, s[pps_pkg::SLOT_FW-1:0], a[pps_pkg::TF_W-1:0],
              b[pps_pkg::TF_W-1:0], p[pps_pkg::PRIO_W-1:0]);
  endtask

  // load fields are don't-care on a tick, so they carry noise
  task automatic tick();
    send_item(pps_pkg::REQ_TICK, pps_pkg::SLOT_FW'($urandom_range(SLOTS - 1)),
              pps_pkg::TF_W'($urandom), pps_pkg::TF_W'($urandom),
              pps_pkg::PRIO_W'($urandom));
  endtask

  task automatic maybe_idle();
    while ($urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_outs.size() != 0);
  endtask

  function automatic int near_now(int span);
    int t;
    t = sched_time + int'($urandom_range(span));
    return (t > TIME_TOP) ? TIME_TOP : t;
  endfunction

  task automatic test_idle_and_single();
    tick();
    load_slot(0, 0, 1, 0);
    tick();
    wait_idle();
  endtask

  task automatic test_preemption();
    load_slot(1, sched_time, 6, 9);
    tick();
    tick();
    load_slot(2, sched_time, 3, 4);
    tick();
    // same priority, later arrival: no displacement
    load_slot(3, sched_time, 2, 4);
    tick();
    tick();
    tick();
    // never arrives within the run
    load_slot(7, TIME_TOP, TIME_TOP, 15);
    load_slot(4, 0, 1, 0);
    tick();
    tick();
    tick();
    wait_idle();
  endtask

  task automatic test_reload_running();
    load_slot(6, sched_time, 8, 0);
    tick();
    tick();
    load_slot(6, sched_time, 2, 1);
    tick();
    tick();
    wait_idle();
  endtask

  task automatic test_zero_burst();
    load_slot(5, sched_time, 0, 0);
    tick();
    tick();
    wait_idle();
  endtask

  task automatic test_random_traffic(input int n_items);
    int b;
    int a;
    int p;
    for (int n = 0; n < n_items; n++) begin
      maybe_idle();
      if ($urandom_range(99) < 2) wait_idle();
      if ($urandom_range(99) < 30) begin
        a = ($urandom_range(99) < 80) ? near_now(12) : int'($urandom_range(TIME_TOP));
        b = ($urandom_range(99) < 88) ? int'($urandom_range(12, 1)) :
                                        int'($urandom_range(TIME_TOP, 1));
        p = ($urandom_range(1)) ? int'($urandom_range(3)) : int'($urandom_range(15));
        load_slot(int'($urandom_range(SLOTS - 1)), a, b, p);
      end else begin
        tick();
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_and_single();
    test_preemption();
    test_reload_running();
    test_zero_burst();
    test_random_traffic(1675);
    repeat (2 * SLOTS + 8) @(posedge clk);
    if (fail_count == 0 && pending_outs.size() == 0) begin
      $display("[preemptive_priority_scheduler_unit] OK");
    end else begin
      $display("[preemptive_priority_scheduler_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[preemptive_priority_scheduler_unit] ERROR");
    $finish;
  end

endmodule
